>>> hdl/dh_link_transform_macros.svh
// Assertion helpers for dh_link_transform.sv, the only RTL file that includes them.
`ifndef DH_LINK_TRANSFORM_MACROS_SVH
`define DH_LINK_TRANSFORM_MACROS_SVH

// Same-cycle implication.
`define DHL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DHL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/dhl_pkg.sv
`timescale 1ns / 1ps
package dhl_pkg;

  localparam longint unsigned PI_Q62   = 64'hC90FDAA22168C235;
  localparam longint unsigned GAIN_Q32 = 64'd2608131496;

  localparam int WORD_W = 32;
  localparam int ROT_W  = 32;
  localparam int UW     = 34;
  localparam int CX_W   = 36;
  localparam int NUM_T  = 12;

  typedef enum logic [2:0] {
    CFG_TWIST_ANGLE        = 3'd0,
    CFG_LINK_LENGTH        = 3'd1,
    CFG_FIXED_JOINT_ANGLE  = 3'd2,
    CFG_FIXED_JOINT_LENGTH = 3'd3,
    CFG_JOINT_OFFSET       = 3'd4,
    CFG_IS_REVOLUTE        = 3'd5,
    CFG_MODIFIED           = 3'd6,
    CFG_REVERSE_JOINT      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] sa;
    logic signed [ROT_W-1:0] ca;
    logic signed [ROT_W-1:0] st;
    logic signed [ROT_W-1:0] ct;
  } trig_t;

  // Long division by shift and subtract, evaluated at elaboration only.
  function automatic longint unsigned udiv_const(input longint unsigned n,
                                                 input longint unsigned dv);
    longint unsigned qt;
    longint unsigned rm;
    qt = 0;
    rm = 0;
    for (int b = 63; b >= 0; b--) begin
      rm = (rm << 1) | ((n >> b) & 64'd1);
      qt = qt << 1;
      if (rm >= dv) begin
        rm = rm - dv;
        qt = qt | 64'd1;
      end
    end
    return qt;
  endfunction

  function automatic longint unsigned atan_q32(input int unsigned i);
    longint unsigned s;
    longint unsigned t;
    logic sub;
    logic done;
    int unsigned sh;
    s = 0;
    sub = 1'b0;
    done = 1'b0;
    if (i == 0) begin
      s = PI_Q62 >> 2;
    end else begin
      for (int unsigned k = 0; k < 64; k++) begin
        sh = i * (2 * k + 1);
        if (sh >= 62) done = 1'b1;
        if (!done) begin
          t = udiv_const(64'd1 << (62 - sh), 64'(2 * k + 1));
          s = sub ? s - t : s + t;
          sub = !sub;
        end
      end
    end
    return (s + (64'd1 << 29)) >> 30;
  endfunction

  function automatic int red_steps(input longint unsigned tp, input longint unsigned umax);
    int k;
    k = 0;
    while ((tp << k) <= umax) k++;
    return k;
  endfunction

  function automatic logic signed [ROT_W-1:0] cordic_out(input logic signed [CX_W-1:0] v,
                                                         input logic neg);
    logic signed [CX_W-1:0] r;
    logic signed [ROT_W-1:0] s;
    r = (v + CX_W'(2)) >>> 2;
    if (r > CX_W'(32'sd1073741824)) s = 32'sd1073741824;
    else if (r < -CX_W'(32'sd1073741824)) s = -32'sd1073741824;
    else s = r[ROT_W-1:0];
    return neg ? -s : s;
  endfunction

  function automatic logic signed [ROT_W-1:0] rot_round(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + 64'sd536870912) >>> 30;
    if (r > 64'sd1073741824) return 32'sd1073741824;
    if (r < -64'sd1073741824) return -32'sd1073741824;
    return r[ROT_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] len_round(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + 64'sd536870912) >>> 30;
    if (r > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (r < -64'sd2147483648) return 32'sh80000000;
    return r[WORD_W-1:0];
  endfunction

endpackage

>>> hdl/dhl_trig.sv
`timescale 1ns / 1ps
module dhl_trig #(
  parameter int CORDIC_STEPS    = 24,
  parameter int ANGLE_FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [31:0]            angle_a,
  input  logic signed [31:0]            angle_b,
  input  logic [31:0]                   side_in,
  output logic                          out_valid,
  output dhl_pkg::trig_t                trig,
  output logic [31:0]                   side_out
);
  import dhl_pkg::*;

  localparam int F = ANGLE_FRAC_BITS;
  localparam longint unsigned TP   = (PI_Q62 + (64'd1 << (60 - F))) >> (61 - F);
  localparam longint unsigned PI32 = (PI_Q62 + (64'd1 << 29)) >> 30;
  localparam longint unsigned NM   = (64'd2147483648 + TP - 64'd1) / TP;
  localparam longint unsigned OFF  = TP * NM;
  localparam longint unsigned UMAX = 64'd2147483647 + OFF;
  localparam int KS = red_steps(TP, UMAX);
  localparam int L  = KS + CORDIC_STEPS + 4;
  localparam int ZW = CX_W;

  logic        vp [L];
  logic [31:0] sp [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) vp[k] <= 1'b0;
    end else if (en) begin
      vp[0] <= in_valid;
      for (int k = 1; k < L; k++) vp[k] <= vp[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp[0] <= side_in;
      for (int k = 1; k < L; k++) sp[k] <= sp[k-1];
    end
  end

  logic signed [31:0]    ang  [2];
  logic signed [ROT_W-1:0] sn_l [2];
  logic signed [ROT_W-1:0] cs_l [2];

  assign ang[0] = angle_a;
  assign ang[1] = angle_b;

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic [UW-1:0]          u  [KS+1];
    logic signed [ZW-1:0]   rc;
    logic signed [ZW-1:0]   zc;
    logic signed [ZW:0]     z2;
    logic signed [ZW-1:0]   cz [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cx [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cy [CORDIC_STEPS+1];
    logic                   ng [CORDIC_STEPS+1];

    always_ff @(posedge clk) begin
      if (en) u[0] <= UW'(ang[ln]) + UW'(OFF);
    end

    for (genvar j = 0; j < KS; j++) begin : g_red
      localparam logic [UW-1:0] SUBV = UW'(TP << (KS - 1 - j));
      always_ff @(posedge clk) begin
        if (en) u[j+1] <= (u[j] >= SUBV) ? u[j] - SUBV : u[j];
      end
    end

    assign rc = ({u[KS], 1'b0} > (UW+1)'(TP)) ? $signed(ZW'(u[KS])) - $signed(ZW'(TP))
                                               : $signed(ZW'(u[KS]));

    always_ff @(posedge clk) begin
      if (en) zc <= rc <<< (32 - F);
    end

    assign z2 = {zc, 1'b0};

    always_ff @(posedge clk) begin
      if (en) begin
        if (z2 > $signed((ZW+1)'(PI32))) begin
          cz[0] <= zc - $signed(ZW'(PI32));
          ng[0] <= 1'b1;
        end else if (z2 < -$signed((ZW+1)'(PI32))) begin
          cz[0] <= zc + $signed(ZW'(PI32));
          ng[0] <= 1'b1;
        end else begin
          cz[0] <= zc;
          ng[0] <= 1'b0;
        end
      end
    end

    assign cx[0] = $signed(CX_W'(GAIN_Q32));
    assign cy[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [ZW-1:0] DA = $signed(ZW'(atan_q32(i)));
      always_ff @(posedge clk) begin
        if (en) begin
          ng[i+1] <= ng[i];
          if (cz[i] >= 0) begin
            cx[i+1] <= cx[i] - (cy[i] >>> i);
            cy[i+1] <= cy[i] + (cx[i] >>> i);
            cz[i+1] <= cz[i] - DA;
          end else begin
            cx[i+1] <= cx[i] + (cy[i] >>> i);
            cy[i+1] <= cy[i] - (cx[i] >>> i);
            cz[i+1] <= cz[i] + DA;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs_l[ln] <= cordic_out(cx[CORDIC_STEPS], ng[CORDIC_STEPS]);
        sn_l[ln] <= cordic_out(cy[CORDIC_STEPS], ng[CORDIC_STEPS]);
      end
    end
  end

  assign trig.sa   = sn_l[0];
  assign trig.ca   = cs_l[0];
  assign trig.st   = sn_l[1];
  assign trig.ct   = cs_l[1];
  assign out_valid = vp[L-1];
  assign side_out  = sp[L-1];

endmodule

>>> hdl/dhl_mat.sv
`timescale 1ns / 1ps
module dhl_mat (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  dhl_pkg::trig_t       trig,
  input  logic signed [31:0]   q,
  input  logic signed [31:0]   link_length,
  input  logic signed [31:0]   fixed_joint_length,
  input  logic                 is_revolute,
  input  logic                 modified_convention,
  output logic                 out_valid,
  output logic [383:0]         out_data
);
  import dhl_pkg::*;

  logic                    pv;
  logic signed [ROT_W-1:0] st, ct, sa, ca;
  logic signed [31:0]      d;
  logic signed [63:0]      p_stca, p_stsa, p_ctca, p_ctsa, p_la, p_lb;
  logic signed [31:0]      d_in, nsa;
  logic signed [31:0]      m [NUM_T];

  assign d_in = is_revolute ? fixed_joint_length : q;
  assign nsa  = -trig.sa;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      pv <= in_valid;
      out_valid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= trig.st;
      ct <= trig.ct;
      sa <= trig.sa;
      ca <= trig.ca;
      d  <= d_in;
      p_stca <= trig.st * trig.ca;
      p_stsa <= trig.st * trig.sa;
      p_ctca <= trig.ct * trig.ca;
      p_ctsa <= trig.ct * trig.sa;
      if (modified_convention) begin
        p_la <= d_in * nsa;
        p_lb <= d_in * trig.ca;
      end else begin
        p_la <= link_length * trig.ct;
        p_lb <= link_length * trig.st;
      end
    end
  end

  always_comb begin
    if (modified_convention) begin
      m[0]  = ct;
      m[1]  = -st;
      m[2]  = '0;
      m[3]  = link_length;
      m[4]  = rot_round(p_stca);
      m[5]  = rot_round(p_ctca);
      m[6]  = -sa;
      m[7]  = len_round(p_la);
      m[8]  = rot_round(p_stsa);
      m[9]  = rot_round(p_ctsa);
      m[10] = ca;
      m[11] = len_round(p_lb);
    end else begin
      m[0]  = ct;
      m[1]  = -rot_round(p_stca);
      m[2]  = rot_round(p_stsa);
      m[3]  = len_round(p_la);
      m[4]  = st;
      m[5]  = rot_round(p_ctca);
      m[6]  = -rot_round(p_ctsa);
      m[7]  = len_round(p_lb);
      m[8]  = '0;
      m[9]  = sa;
      m[10] = ca;
      m[11] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_T; j++) out_data[32*j +: 32] <= m[j];
    end
  end

endmodule

>>> hdl/dh_link_transform.sv
`timescale 1ns / 1ps
// Denavit-Hartenberg link transform. Each joint_value item gives one item holding
// the top three rows of the link matrix. The pipeline takes one item per clock while
// the output is not stalled. The modulo-2*pi reduction uses 2 compare-subtract
// stages at ANGLE_FRAC_BITS = 28. Twist and joint angles run through two CORDIC
// lanes side by side, one iteration per stage. The whole pipe holds while the
// output item is not taken. Write the configuration only while no item is in flight.
module dh_link_transform #(
  parameter int CORDIC_STEPS    = 24,
  parameter int ANGLE_FRAC_BITS = 28
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // joint_value
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [383:0]  m_tdata,   // t00 t01 t02 t03 t10 t11 t12 t13 t20 t21 t22 t23
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_wdata
);
  import dhl_pkg::*;
  `include "dh_link_transform_macros.svh"

  logic signed [31:0] twist_angle, link_length, fixed_joint_angle;
  logic signed [31:0] fixed_joint_length, joint_offset;
  logic               is_revolute, modified_convention, reverse_joint;

  always_ff @(posedge clk) begin
    if (rst) begin
      twist_angle <= '0;
      link_length <= '0;
      fixed_joint_angle <= '0;
      fixed_joint_length <= '0;
      joint_offset <= '0;
      is_revolute <= 1'b1;
      modified_convention <= 1'b0;
      reverse_joint <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_TWIST_ANGLE:        twist_angle <= cfg_wdata;
        CFG_LINK_LENGTH:        link_length <= cfg_wdata;
        CFG_FIXED_JOINT_ANGLE:  fixed_joint_angle <= cfg_wdata;
        CFG_FIXED_JOINT_LENGTH: fixed_joint_length <= cfg_wdata;
        CFG_JOINT_OFFSET:       joint_offset <= cfg_wdata;
        CFG_IS_REVOLUTE:        is_revolute <= cfg_wdata[0];
        CFG_MODIFIED:           modified_convention <= cfg_wdata[0];
        CFG_REVERSE_JOINT:      reverse_joint <= cfg_wdata[0];
        default:                twist_angle <= twist_angle;
      endcase
    end
  end

  logic               en;
  logic               q_valid;
  logic signed [31:0] q;
  logic signed [32:0] qv;
  logic signed [33:0] qsum;
  logic signed [31:0] q_next;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign qv   = reverse_joint ? -33'($signed(s_tdata)) : 33'($signed(s_tdata));
  assign qsum = 34'(qv) + 34'(joint_offset);

  always_comb begin
    if (qsum > 34'sd2147483647) q_next = 32'sh7FFFFFFF;
    else if (qsum < -34'sd2147483648) q_next = 32'sh80000000;
    else q_next = qsum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (en) q_valid <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

  logic        t_valid;
  trig_t       trig;
  logic [31:0] t_side;

  dhl_trig #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_trig (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .angle_a   (twist_angle),
    .angle_b   (is_revolute ? q : fixed_joint_angle),
    .side_in   (q),
    .out_valid (t_valid),
    .trig      (trig),
    .side_out  (t_side)
  );

  dhl_mat u_mat (
    .clk                 (clk),
    .rst                 (rst),
    .en                  (en),
    .in_valid            (t_valid),
    .trig                (trig),
    .q                   ($signed(t_side)),
    .link_length         (link_length),
    .fixed_joint_length  (fixed_joint_length),
    .is_revolute         (is_revolute),
    .modified_convention (modified_convention),
    .out_valid           (m_tvalid),
    .out_data            (m_tdata)
  );

  `DHL_ASSERT_NEXT(a_front_holds, !en && q_valid, q_valid, "front stage lost item on stall")
  `DHL_ASSERT_IMP(a_std_zero, m_tvalid && !modified_convention, m_tdata[287:256] == '0, "t20 nonzero")
  `DHL_ASSERT_IMP(a_rot_range, m_tvalid, $signed(m_tdata[31:0]) <= 32'sd1073741824 && $signed(m_tdata[31:0]) >= -32'sd1073741824, "t00 out of range")

endmodule

>>> bench/tb_dh_link_transform.sv
`timescale 1ns / 1ps
module tb_dh_link_transform;
  import dhl_pkg::*;

  localparam int STEPS = 24;
  localparam int AFB = 28;
  localparam longint unsigned PI_C = 64'hC90FDAA22168C235;
  localparam longint GAIN_C = 64'sd2608131496;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [31:0] s_tdata = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [383:0] m_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_addr = 0;
  logic [31:0] cfg_wdata = 0;

  dh_link_transform i_dut (.*);

  always #1 clk = ~clk;

  longint twist, alen, fangle, flen, joff;
  bit revolute, modified, reversed;
  logic [383:0] matrix_q[$];
  int errors, n_items, n_rows;
  bit calm, hold_off;
  longint atan_tab[48];

  function automatic longint shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-(v + 1)) >>> s) + 1);
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint atan_of(int i);
    longint unsigned s, t;
    bit sub;
    int sh;
    s = 0;
    sub = 0;
    if (i == 0) s = PI_C >> 2;
    else
      for (int k = 0; k < 64; k++) begin
        sh = i * (2 * k + 1);
        if (sh >= 62) break;
        t = (64'd1 << (62 - sh)) / longint'(2 * k + 1);
        s = sub ? s - t : s + t;
        sub = !sub;
      end
    return longint'((s + (64'd1 << 29)) >> 30);
  endfunction

  task automatic sincos(longint ang, output longint sn, output longint cs);
    longint tp, pi32, r, z, x, y, dx, dy;
    bit neg;
    tp = longint'((PI_C + (64'd1 << (60 - AFB))) >> (61 - AFB));
    pi32 = longint'((PI_C + (64'd1 << 29)) >> 30);
    neg = 0;
    r = ang % tp;
    if (r < 0) r += tp;
    if (2 * r > tp) r -= tp;
    z = r * (64'sd1 << (32 - AFB));
    if (2 * z > pi32) begin
      z -= pi32;
      neg = 1;
    end else if (2 * z < -pi32) begin
      z += pi32;
      neg = 1;
    end
    x = GAIN_C;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    x = clampv(shr(x + 2, 2), -(64'sd1 << 30), 64'sd1 << 30);
    y = clampv(shr(y + 2, 2), -(64'sd1 << 30), 64'sd1 << 30);
    cs = neg ? -x : x;
    sn = neg ? -y : y;
  endtask

  function automatic longint rmul(longint p, longint q);
    return clampv(shr(p * q + (64'sd1 << 29), 30), -(64'sd1 << 30), 64'sd1 << 30);
  endfunction

  function automatic longint lmul(longint l, longint r);
    return clampv(shr(l * r + (64'sd1 << 29), 30), -64'sd2147483648, 64'sd2147483647);
  endfunction

  task automatic link_matrix(logic [31:0] jv, output logic [383:0] mat);
    longint q, sa, ca, st, ct, d;
    longint t[12];
    q = sx(jv);
    if (reversed) q = -q;
    q = clampv(q + joff, -64'sd2147483648, 64'sd2147483647);
    sincos(twist, sa, ca);
    if (revolute) begin
      sincos(q, st, ct);
      d = flen;
    end else begin
      sincos(fangle, st, ct);
      d = q;
    end
    if (modified) begin
      t = '{ct, -st, 0, alen, rmul(st, ca), rmul(ct, ca), -sa, lmul(d, -sa),
            rmul(st, sa), rmul(ct, sa), ca, lmul(d, ca)};
    end else begin
      t = '{ct, -rmul(st, ca), rmul(st, sa), lmul(alen, ct), st, rmul(ct, ca),
            -rmul(ct, sa), lmul(alen, st), 0, sa, ca, d};
    end
    for (int j = 0; j < 12; j++) mat[32*j +: 32] = t[j][31:0];
  endtask

  task automatic report(string what, int j, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 20) $display("mismatch %s entry %0d: got %h want %h", what, j, got, want);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      CFG_TWIST_ANGLE: twist = sx(v);
      CFG_LINK_LENGTH: alen = sx(v);
      CFG_FIXED_JOINT_ANGLE: fangle = sx(v);
      CFG_FIXED_JOINT_LENGTH: flen = sx(v);
      CFG_JOINT_OFFSET: joff = sx(v);
      CFG_IS_REVOLUTE: revolute = v[0];
      CFG_MODIFIED: modified = v[0];
      CFG_REVERSE_JOINT: reversed = v[0];
    endcase
  endtask

  task automatic send_joint(logic [31:0] jv);
    logic [383:0] mat;
    while (!calm && $urandom_range(99) < 15) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= jv;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    link_matrix(jv, mat);
    matrix_q.push_back(mat);
    n_items++;
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3FFFFFFF) - 32'h20000000;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (matrix_q.size() == 0) report("unexpected", 0, 0, 0);
      else begin
        logic [383:0] want;
        want = matrix_q.pop_front();
        for (int j = 0; j < 12; j++)
          if (m_tdata[32*j +: 32] !== want[32*j +: 32])
            report("field", j, m_tdata[32*j +: 32], want[32*j +: 32]);
        n_rows++;
      end
    end
    m_tready <= hold_off ? 0 : (calm || $urandom_range(99) >= 15);
  end

  task automatic test_directed;
    logic [31:0] v[] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'hFFFFFFFF,
                         32'h3243F6A9, 32'hCDBC0957, 32'h1921FB54, 32'h6487ED51,
                         32'h10000000};
    foreach (v[i]) send_joint(v[i]);
    drain();
    write_reg(CFG_TWIST_ANGLE, 32'h1921FB54);
    write_reg(CFG_LINK_LENGTH, 32'h7FFFFFFF);
    write_reg(CFG_FIXED_JOINT_LENGTH, 32'h80000000);
    write_reg(CFG_JOINT_OFFSET, 32'h7FFFFFFF);
    write_reg(CFG_REVERSE_JOINT, 1);
    foreach (v[i]) send_joint(v[i]);
    drain();
    write_reg(CFG_JOINT_OFFSET, 32'h80000000);
    write_reg(CFG_IS_REVOLUTE, 0);
    write_reg(CFG_MODIFIED, 1);
    write_reg(CFG_FIXED_JOINT_ANGLE, 32'h80000000);
    send_joint(32'h7FFFFFFF);
    send_joint(32'h80000000);
    send_joint(32'h00010000);
    drain();
  endtask

  task automatic test_backpressure;
    hold_off = 1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 80; i++) send_joint($urandom);
    join
    drain();
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_TWIST_ANGLE, rnd_word());
      write_reg(CFG_LINK_LENGTH, rnd_word());
      write_reg(CFG_FIXED_JOINT_ANGLE, rnd_word());
      write_reg(CFG_FIXED_JOINT_LENGTH, rnd_word());
      write_reg(CFG_JOINT_OFFSET, ($urandom_range(3) == 0) ? rnd_word() : 0);
      write_reg(CFG_IS_REVOLUTE, $urandom_range(1));
      write_reg(CFG_MODIFIED, $urandom_range(1));
      write_reg(CFG_REVERSE_JOINT, $urandom_range(1));
      calm = (ph == 5);
      for (int i = 0; i < 100; i++) send_joint(rnd_word());
      calm = 0;
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < 48; i++) atan_tab[i] = atan_of(i);
    twist = 0; alen = 0; fangle = 0; flen = 0; joff = 0;
    revolute = 1; modified = 0; reversed = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    $display("%0d joint values sent, %0d matrices checked over 15 register settings",
             n_items, n_rows);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end

endmodule
